### rtl/srpv_pkg.sv
`timescale 1ns / 1ps

package srpv_pkg;

  localparam int ID_BYTES_DEFAULT    = 4;
  localparam int QUEUE_DEPTH_DEFAULT = 4;

  localparam logic [31:0] REC_MAGIC = 32'h4452_5444;
  localparam logic [31:0] FNV_BASIS = 32'd2166136261;
  localparam logic [31:0] FNV_PRIME = 32'd16777619;

  // Configuration register indexes
  localparam logic REG_EXPECTED_VERSION = 1'b0;
  localparam logic REG_MAX_PAYLOAD      = 1'b1;

  localparam logic [15:0] EXPECTED_VERSION_RESET = 16'd1;
  localparam logic [20:0] MAX_PAYLOAD_RESET      = 21'd4096;

  // Result kinds
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  // Verdict codes
  localparam logic [2:0] STATUS_OK          = 3'd0;
  localparam logic [2:0] STATUS_CORRUPT     = 3'd1;
  localparam logic [2:0] STATUS_BAD_VERSION = 3'd2;
  localparam logic [2:0] STATUS_BAD_ID      = 3'd3;
  localparam logic [2:0] STATUS_TOO_LARGE   = 3'd4;
  localparam logic [2:0] STATUS_CHECKSUM    = 3'd5;

  typedef struct packed {
    logic       has_byte;
    logic [7:0] data_byte;
    logic       end_of_blob;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  payload_byte;
    logic [2:0]  status;
    logic [31:0] device_id;
    logic [15:0] version;
    logic [31:0] payload_length;
    logic        final_item;
  } out_item_t;

  // One queued request: an optional payload byte, then an optional verdict.
  // Both share the header snapshot.
  typedef struct packed {
    logic        pay_valid;
    logic [7:0]  pay_byte;
    logic        verdict_valid;
    logic [2:0]  status;
    logic [31:0] device_id;
    logic [15:0] version;
    logic [31:0] payload_length;
  } rec_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

### rtl/srpv_front.sv
`timescale 1ns / 1ps

module srpv_front #(
  parameter int ID_BYTES = srpv_pkg::ID_BYTES_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_en,
  input  logic                 cfg_addr,
  input  logic [20:0]          cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  srpv_pkg::in_item_t   in_data,
  output logic                 push,
  output srpv_pkg::rec_entry_t push_entry,
  input  srpv_pkg::queue_status_t q_status
);
  import srpv_pkg::*;

  localparam int ID_W    = 8 * ID_BYTES;
  localparam int ID_BASE = 8;
  localparam int LEN_BASE = 8 + ID_BYTES;
  localparam int SUM_BASE = LEN_BASE + 4;
  localparam int HDR_LEN = 16 + ID_BYTES;

  logic [15:0] expected_version;
  logic [20:0] max_payload_bytes;

  logic [31:0]     byte_position;
  logic [31:0]     magic_word;
  logic [15:0]     header_version;
  logic [ID_W-1:0] header_device_id;
  logic [31:0]     header_length;
  logic [31:0]     header_checksum;
  logic [31:0]     running_hash;

  logic [31:0]     byte_position_next;
  logic [31:0]     magic_word_next;
  logic [15:0]     header_version_next;
  logic [ID_W-1:0] header_device_id_next;
  logic [31:0]     header_length_next;
  logic [31:0]     header_checksum_next;
  logic [31:0]     running_hash_next;

  logic        accept;
  logic        take_byte;
  logic [32:0] pay_end;
  logic        in_payload;
  logic        header_good;
  logic        pay_out;
  logic [31:0] hash_mix;
  logic [2:0]  verdict;
  logic [63:0] id_wide;

  assign in_stall  = q_status.full;
  assign accept    = in_valid && !in_stall;
  assign take_byte = accept && in_data.has_byte;

  // Pay end is fixed while payload bytes arrive; header length is complete by then.
  assign pay_end    = 33'(HDR_LEN) + {1'b0, header_length};
  assign in_payload = (byte_position >= 32'(HDR_LEN)) && ({1'b0, byte_position} < pay_end);
  assign hash_mix   = running_hash ^ {24'd0, in_data.data_byte};

  assign header_good = (magic_word == REC_MAGIC) &&
                       (header_version == expected_version) &&
                       (header_device_id != '0) &&
                       (header_length <= {11'd0, max_payload_bytes});

  assign pay_out = take_byte && in_payload && header_good;

  always_comb begin
    magic_word_next       = magic_word;
    header_version_next   = header_version;
    header_device_id_next = header_device_id;
    header_length_next    = header_length;
    header_checksum_next  = header_checksum;
    running_hash_next     = running_hash;
    byte_position_next    = byte_position;
    if (take_byte) begin
      for (int i = 0; i < 4; i++) begin
        if (byte_position == 32'(i))
          magic_word_next[8*i +: 8] = magic_word[8*i +: 8] | in_data.data_byte;
        if (byte_position == 32'(LEN_BASE + i))
          header_length_next[8*i +: 8] = header_length[8*i +: 8] | in_data.data_byte;
        if (byte_position == 32'(SUM_BASE + i))
          header_checksum_next[8*i +: 8] = header_checksum[8*i +: 8] | in_data.data_byte;
      end
      for (int i = 0; i < 2; i++) begin
        if (byte_position == 32'(4 + i))
          header_version_next[8*i +: 8] = header_version[8*i +: 8] | in_data.data_byte;
      end
      for (int i = 0; i < ID_BYTES; i++) begin
        if (byte_position == 32'(ID_BASE + i))
          header_device_id_next[8*i +: 8] = header_device_id[8*i +: 8] | in_data.data_byte;
      end
      if (in_payload)
        running_hash_next = 32'(hash_mix * FNV_PRIME);
      if (byte_position != '1)
        byte_position_next = byte_position + 32'd1;
    end
  end

  always_comb begin
    if (byte_position_next < 32'(HDR_LEN))
      verdict = STATUS_CORRUPT;
    else if ((magic_word_next != REC_MAGIC) || (header_version_next != expected_version))
      verdict = STATUS_BAD_VERSION;
    else if (header_device_id_next == '0)
      verdict = STATUS_BAD_ID;
    else if (header_length_next > {11'd0, max_payload_bytes})
      verdict = STATUS_TOO_LARGE;
    else if ({1'b0, byte_position_next} != 33'(HDR_LEN) + {1'b0, header_length_next})
      verdict = STATUS_CORRUPT;
    else if (header_checksum_next != running_hash_next)
      verdict = STATUS_CHECKSUM;
    else
      verdict = STATUS_OK;
  end

  assign id_wide = 64'(header_device_id_next);

  assign push = pay_out || (accept && in_data.end_of_blob);

  always_comb begin
    push_entry.pay_valid      = pay_out;
    push_entry.pay_byte       = in_data.data_byte;
    push_entry.verdict_valid  = in_data.end_of_blob;
    push_entry.status         = verdict;
    push_entry.device_id      = id_wide[31:0];
    push_entry.version        = header_version_next;
    push_entry.payload_length = header_length_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_version  <= EXPECTED_VERSION_RESET;
      max_payload_bytes <= MAX_PAYLOAD_RESET;
    end else if (cfg_en) begin
      case (cfg_addr)
        REG_EXPECTED_VERSION: expected_version  <= cfg_data[15:0];
        REG_MAX_PAYLOAD:      max_payload_bytes <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && in_data.end_of_blob)) begin
      byte_position    <= '0;
      magic_word       <= '0;
      header_version   <= '0;
      header_device_id <= '0;
      header_length    <= '0;
      header_checksum  <= '0;
      running_hash     <= FNV_BASIS;
    end else begin
      byte_position    <= byte_position_next;
      magic_word       <= magic_word_next;
      header_version   <= header_version_next;
      header_device_id <= header_device_id_next;
      header_length    <= header_length_next;
      header_checksum  <= header_checksum_next;
      running_hash     <= running_hash_next;
    end
  end

endmodule

### rtl/srpv_queue.sv
`timescale 1ns / 1ps

module srpv_queue #(
  parameter int DEPTH = srpv_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    wr_en,
  input  srpv_pkg::rec_entry_t    wr_data,
  input  logic                    rd_en,
  output srpv_pkg::rec_entry_t    rd_data,
  output srpv_pkg::queue_status_t status
);
  import srpv_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  rec_entry_t       slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign status.full  = (count == CNT_W'(DEPTH));
  assign status.empty = (count == '0);
  assign rd_data      = slots[rd_ptr];

  assign do_wr = wr_en && !status.full;
  assign do_rd = rd_en && !status.empty;

  always_ff @(posedge clk) begin
    if (do_wr)
      slots[wr_ptr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr)
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      if (do_rd)
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      case ({do_wr, do_rd})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

### rtl/srpv_back.sv
`timescale 1ns / 1ps

module srpv_back (
  input  logic                    clk,
  input  logic                    rst,
  input  srpv_pkg::rec_entry_t    head,
  input  srpv_pkg::queue_status_t q_status,
  output logic                    pop,
  output logic                    out_valid,
  input  logic                    out_stall,
  output srpv_pkg::out_item_t     out_data
);
  import srpv_pkg::*;

  logic pay_sent;
  logic load;
  logic have;
  logic send_pay;

  assign load = !out_valid || !out_stall;
  assign have = load && !q_status.empty;
  // Payload byte goes first; a verdict in the same request stays at the queue head until the byte is sent.
  assign send_pay = head.pay_valid && !pay_sent;
  assign pop = have && (!send_pay || !head.verdict_valid);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pay_sent  <= 1'b0;
    end else if (load) begin
      out_valid <= have;
      if (have)
        pay_sent <= send_pay && head.verdict_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (have) begin
      out_data.kind           <= send_pay ? KIND_PAYLOAD : KIND_VERDICT;
      out_data.payload_byte   <= send_pay ? head.pay_byte : 8'd0;
      out_data.status         <= send_pay ? STATUS_OK : head.status;
      out_data.device_id      <= head.device_id;
      out_data.version        <= head.version;
      out_data.payload_length <= head.payload_length;
      out_data.final_item     <= !send_pay;
    end
  end

endmodule

### rtl/state_record_parse_validate.sv
`timescale 1ns / 1ps

// Checked record parser. Feed a stored record one request per cycle on the
// in channel (in_valid / in_stall / in_data): a byte with has_byte set, and
// end_of_blob on the last request of the record (alone or with a byte).
// Payload bytes of a record with a good header come out on the out channel
// as kind payload; the request carrying end_of_blob adds one verdict with
// final_item set. Bytes are hashed with FNV-1a 32 and checked against the
// header checksum.
// A result is written into a queue slot and then loaded into the output
// register. Throughput: one request per cycle while in_stall is low; a
// request that ends a record with a payload byte yields two results, which
// leave the output register one after the other.
// The parser state and hash update once per request; a short queue
// decouples it from the output register. When out_stall holds, the queue
// fills and in_stall rises. Reset clears the parser, the queue and
// out_valid, and loads the register defaults (version 1, maximum 4096).
// Write configuration only while the block is idle.
module state_record_parse_validate #(
  parameter int ID_BYTES    = srpv_pkg::ID_BYTES_DEFAULT,
  parameter int QUEUE_DEPTH = srpv_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_en,
  input  logic                cfg_addr,
  input  logic [20:0]         cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  srpv_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output srpv_pkg::out_item_t out_data
);
  import srpv_pkg::*;

  logic          push;
  rec_entry_t    push_entry;
  logic          pop;
  rec_entry_t    head;
  queue_status_t q_status;

  srpv_front #(.ID_BYTES(ID_BYTES)) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_en     (cfg_en),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .push       (push),
    .push_entry (push_entry),
    .q_status   (q_status)
  );

  srpv_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (push),
    .wr_data (push_entry),
    .rd_en   (pop),
    .rd_data (head),
    .status  (q_status)
  );

  srpv_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .q_status  (q_status),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

### rtl/srpv_checker.sv
`timescale 1ns / 1ps

module srpv_checker (
  input logic                clk,
  input logic                rst,
  input logic                out_valid,
  input logic                out_stall,
  input srpv_pkg::out_item_t out_data
);
  import srpv_pkg::*;

  // Verdicts and only verdicts close a record.
  a_final_is_verdict: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.final_item == (out_data.kind == KIND_VERDICT)))
    else $error("final_item disagrees with kind");

  // Payload results carry no status; verdicts carry no byte.
  a_field_split: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((out_data.kind == KIND_PAYLOAD) ? (out_data.status == STATUS_OK)
                                                   : (out_data.payload_byte == 8'd0)))
    else $error("payload or status field set on the wrong kind");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.status <= STATUS_CHECKSUM))
    else $error("status code out of range");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("out_valid high after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed");

endmodule

bind state_record_parse_validate srpv_checker u_srpv_checker (.*);
